FILE: sv/lcd_mode_timing_controller_top_assert.svh
// Assertion macros for the LCD mode timing controller.
`ifndef LCD_MODE_TIMING_CONTROLLER_TOP_ASSERT_SVH
`define LCD_MODE_TIMING_CONTROLLER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define LMTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define LMTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LMTC_ASSERT(label, prop, msg)
`define LMTC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/lmtc_pkg.sv
// Types, codes and reset values shared by the LCD mode timing controller.
package lmtc_pkg;

	localparam int unsigned ACC_W   = 16;
	localparam int unsigned TIME_W  = 10;
	localparam int unsigned LINE_W  = 8;
	localparam int unsigned BLANK_W = 6;
	localparam int unsigned CYC_W   = 8;
	localparam int unsigned EN_W    = 4;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 10;

	// Mode codes
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_XFER   = 2'd3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_OAM_SCAN_TIME = 3'd0;
	localparam logic [IDX_W-1:0] REG_TRANSFER_TIME = 3'd1;
	localparam logic [IDX_W-1:0] REG_HBLANK_TIME   = 3'd2;
	localparam logic [IDX_W-1:0] REG_VISIBLE_LINES = 3'd3;
	localparam logic [IDX_W-1:0] REG_BLANK_LINES   = 3'd4;

	// Register reset values
	localparam logic [TIME_W-1:0]  RST_OAM_SCAN_TIME = 10'd80;
	localparam logic [TIME_W-1:0]  RST_TRANSFER_TIME = 10'd172;
	localparam logic [TIME_W-1:0]  RST_HBLANK_TIME   = 10'd204;
	localparam logic [LINE_W-1:0]  RST_VISIBLE_LINES = 8'd144;
	localparam logic [BLANK_W-1:0] RST_BLANK_LINES   = 6'd10;

	typedef struct packed {
		logic [TIME_W-1:0]  oam_scan_time;
		logic [TIME_W-1:0]  transfer_time;
		logic [TIME_W-1:0]  hblank_time;
		logic [LINE_W-1:0]  visible_lines;
		logic [BLANK_W-1:0] blank_lines;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		logic [1:0]        mode;
		logic [LINE_W-1:0] line;
	} state_t;

	typedef struct packed {
		logic [LINE_W-1:0] line;
		logic [1:0]        mode;
		logic              coincidence;
		logic              vblank_request;
		logic              status_request;
	} result_t;

endpackage

FILE: sv/lmtc_cfg.sv
// Configuration register file of the LCD mode timing controller.
module lmtc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lmtc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [lmtc_pkg::DATA_W-1:0]  cfg_data,
	output lmtc_pkg::cfg_t               cfg
);
	import lmtc_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.oam_scan_time <= RST_OAM_SCAN_TIME;
			cfg_q.transfer_time <= RST_TRANSFER_TIME;
			cfg_q.hblank_time   <= RST_HBLANK_TIME;
			cfg_q.visible_lines <= RST_VISIBLE_LINES;
			cfg_q.blank_lines   <= RST_BLANK_LINES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OAM_SCAN_TIME: cfg_q.oam_scan_time <= cfg_data[TIME_W-1:0];
				REG_TRANSFER_TIME: cfg_q.transfer_time <= cfg_data[TIME_W-1:0];
				REG_HBLANK_TIME:   cfg_q.hblank_time   <= cfg_data[TIME_W-1:0];
				REG_VISIBLE_LINES: cfg_q.visible_lines <= cfg_data[LINE_W-1:0];
				REG_BLANK_LINES:   cfg_q.blank_lines   <= cfg_data[BLANK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/lmtc_step.sv
// Next-state and result logic for one timing word.
module lmtc_step (
	input  lmtc_pkg::cfg_t                cfg,
	input  lmtc_pkg::state_t              st,
	input  logic [lmtc_pkg::CYC_W-1:0]    elapsed_cycles,
	input  logic [lmtc_pkg::LINE_W-1:0]   compare_line,
	input  logic [lmtc_pkg::EN_W-1:0]     status_enables,
	output lmtc_pkg::state_t              st_next,
	output lmtc_pkg::result_t             res
);
	import lmtc_pkg::*;

	logic [ACC_W:0]    sum;
	logic [ACC_W-1:0]  acc_sat;
	logic [ACC_W-1:0]  oam_ext;
	logic [ACC_W-1:0]  xfer_ext;
	logic [ACC_W-1:0]  hb_ext;
	logic [LINE_W-1:0] line_inc;
	logic [LINE_W:0]   vblank_end;
	logic              vreq;
	logic              coin;

	// Add the elapsed cycles and saturate
	assign sum      = {1'b0, st.acc} + (ACC_W+1)'(elapsed_cycles);
	assign acc_sat  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
	assign oam_ext  = ACC_W'(cfg.oam_scan_time);
	assign xfer_ext = ACC_W'(cfg.transfer_time);
	assign hb_ext   = ACC_W'(cfg.hblank_time);
	assign line_inc = st.line + LINE_W'(1);
	assign vblank_end = (LINE_W+1)'(cfg.visible_lines) + (LINE_W+1)'(cfg.blank_lines);

	// Take at most one mode step
	always_comb begin
		st_next.acc  = acc_sat;
		st_next.mode = st.mode;
		st_next.line = st.line;
		vreq         = 1'b0;
		case (st.mode)
			MODE_OAM: begin
				if (acc_sat > oam_ext) begin
					st_next.mode = MODE_XFER;
					st_next.acc  = acc_sat - oam_ext;
				end
			end
			MODE_XFER: begin
				if (acc_sat > xfer_ext) begin
					st_next.mode = MODE_HBLANK;
					st_next.acc  = acc_sat - xfer_ext;
				end
			end
			MODE_HBLANK: begin
				if (acc_sat >= hb_ext) begin
					st_next.line = line_inc;
					st_next.acc  = acc_sat - hb_ext;
					if (line_inc == cfg.visible_lines) begin
						st_next.mode = MODE_VBLANK;
						vreq         = 1'b1;
					end else begin
						st_next.mode = MODE_OAM;
					end
				end
			end
			default: begin
				// Vertical blank: one line per hblank period
				if (acc_sat > hb_ext) begin
					st_next.acc  = acc_sat - hb_ext;
					if ({1'b0, line_inc} == vblank_end) begin
						st_next.mode = MODE_OAM;
						st_next.line = '0;
					end else begin
						st_next.line = line_inc;
					end
				end
			end
		endcase
	end

	// Report coincidence and the level status request
	assign coin = (st_next.line == compare_line);

	always_comb begin
		res.line           = st_next.line;
		res.mode           = st_next.mode;
		res.coincidence    = coin;
		res.vblank_request = vreq;
		res.status_request = (status_enables[3] && coin)
			|| (status_enables[2] && st_next.mode == MODE_OAM)
			|| (status_enables[1] && st_next.mode == MODE_VBLANK)
			|| (status_enables[0] && st_next.mode == MODE_HBLANK);
	end

endmodule

FILE: sv/lcd_mode_timing_controller_top.sv
// LCD mode timing controller: input register, step logic, result register.
// A word accepted at one edge is held in the input register, and its result is
// written into the result register when the word leaves it, which a stall can hold.
// Throughput: one word per cycle while result_ready does not stall; the state loop is
// one saturating add, compare and subtract. Reset clears valid bits and the mode state
// (accumulator 0, OAM scan, line 0) and loads the register defaults.
`include "lcd_mode_timing_controller_top_assert.svh"
module lcd_mode_timing_controller_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lmtc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lmtc_pkg::DATA_W-1:0]   cfg_data,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  logic [lmtc_pkg::CYC_W-1:0]    elapsed_cycles,
	input  logic [lmtc_pkg::LINE_W-1:0]   compare_line,
	input  logic [lmtc_pkg::EN_W-1:0]     status_enables,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [lmtc_pkg::LINE_W-1:0]   line,
	output logic [1:0]                    mode,
	output logic                          coincidence,
	output logic                          vblank_request,
	output logic                          status_request
);
	import lmtc_pkg::*;

	cfg_t              cfg;
	state_t            st_q;
	state_t            st_next;
	result_t           res;
	result_t           res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic [CYC_W-1:0]  elapsed_s1;
	logic [LINE_W-1:0] compare_s1;
	logic [EN_W-1:0]   enables_s1;
	logic              load_s2;
	logic              adv_s1;
	logic              in_vblank;

	lmtc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lmtc_step u_step (
		.cfg            (cfg),
		.st             (st_q),
		.elapsed_cycles (elapsed_s1),
		.compare_line   (compare_s1),
		.status_enables (enables_s1),
		.st_next        (st_next),
		.res            (res)
	);

	// Handshake: move a word forward whenever the stage ahead frees up
	assign load_s2    = !valid_s2 || result_ready;
	assign adv_s1     = valid_s1 && load_s2;
	assign tick_ready = !valid_s1 || load_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			elapsed_s1 <= elapsed_cycles;
			compare_s1 <= compare_line;
			enables_s1 <= status_enables;
		end
	end

	// Mode state: advance once per word that leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.acc  <= '0;
			st_q.mode <= MODE_OAM;
			st_q.line <= '0;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign result_valid   = valid_s2;
	assign line           = res_s2.line;
	assign mode           = res_s2.mode;
	assign coincidence    = res_s2.coincidence;
	assign vblank_request = res_s2.vblank_request;
	assign status_request = res_s2.status_request;

	assign in_vblank = (st_q.mode == MODE_VBLANK);

	// A vblank request only comes with the vertical blank mode
	`LMTC_ASSERT(a_vreq_mode, result_valid && vblank_request |-> mode == MODE_VBLANK, "stray vblank")
	// State moves only when a word is processed
	`LMTC_ASSERT_NEXT(a_state_hold, !adv_s1, $stable(st_q), "mode state changed without a word")
	// Leaving vertical blank restarts at line zero
	`LMTC_ASSERT_NEXT(a_vblank_exit, in_vblank, in_vblank || st_q.line == '0, "bad vblank exit")
	// A full pipeline under stall takes no new word
	`LMTC_ASSERT(a_full_stall, valid_s1 && !load_s2 |-> !tick_ready, "word taken while pipeline full")

endmodule
